// ----- rtl/core/longest_prefix_route_table_macros.svh -----
// assertion macros for the route table top level
// no dependencies
`ifndef LONGEST_PREFIX_ROUTE_TABLE_MACROS_SVH
`define LONGEST_PREFIX_ROUTE_TABLE_MACROS_SVH
// clocked implication, disabled in reset
`define LPRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// implication checked in the next cycle
`define LPRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- rtl/core/lprt_pkg.sv -----
// shared types and constants for the route table
// no dependencies
`default_nettype none
package lprt_pkg;
    localparam logic [2:0] CMD_LOOKUP = 3'd0;
    localparam logic [2:0] CMD_ADD    = 3'd1;
    localparam logic [2:0] CMD_SETDEF = 3'd2;
    localparam logic [2:0] CMD_UNSET  = 3'd3;
    localparam logic [2:0] CMD_DROP   = 3'd4;
    localparam logic [5:0] MAX_LEN    = 6'd32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;    // capture command beat, clear scan
        logic step;    // process entry at scan index
        logic finish;  // commit and present result
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
    } t_stat;
endpackage
`default_nettype wire

// ----- rtl/core/lprt_ctrl.sv -----
// sequencing state machine for the route table
// depends on lprt_pkg
`default_nettype none
module lprt_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire lprt_pkg::t_stat i_stat,
    output lprt_pkg::t_ctrl      o_ctrl,
    output logic                 o_busy
);
    lprt_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= lprt_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lprt_pkg::ST_IDLE:   if (i_start) n_state = lprt_pkg::ST_SCAN;
            lprt_pkg::ST_SCAN:   if (i_stat.scan_done) n_state = lprt_pkg::ST_FINISH;
            lprt_pkg::ST_FINISH: n_state = lprt_pkg::ST_IDLE;
            default:             n_state = lprt_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ctrl = '0;
        o_busy = 1'b1;
        unique case (r_state)
            lprt_pkg::ST_IDLE: begin
                o_busy      = 1'b0;
                o_ctrl.load = i_start;
            end
            lprt_pkg::ST_SCAN:   o_ctrl.step   = !i_stat.scan_done;
            lprt_pkg::ST_FINISH: o_ctrl.finish = 1'b1;
            default:             o_busy = 1'b1;
        endcase
    end
endmodule
`default_nettype wire

// ----- rtl/core/lprt_datapath.sv -----
// route storage, scan, match and compaction datapath
// depends on lprt_pkg
`default_nettype none
module lprt_datapath #(
    parameter int ROUTE_ENTRIES = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire lprt_pkg::t_ctrl i_ctrl,
    input  wire logic [2:0]      i_cmd,
    input  wire logic [31:0]     i_address,
    input  wire logic [5:0]      i_prefix_len,
    input  wire logic [31:0]     i_gateway_addr,
    input  wire logic            i_gateway_given,
    input  wire logic [3:0]      i_iface_id,
    output lprt_pkg::t_stat      o_stat,
    output logic                 o_strobe,
    output logic                 o_found,
    output logic [31:0]          o_next_hop,
    output logic                 o_next_hop_given,
    output logic [3:0]           o_out_iface,
    output logic                 o_status,
    output logic [$clog2(ROUTE_ENTRIES+1)-1:0] o_count
);
    localparam int IW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int CW = $clog2(ROUTE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(ROUTE_ENTRIES);

    // entry storage
    logic [31:0] r_paddr [ROUTE_ENTRIES];
    logic [31:0] r_gw    [ROUTE_ENTRIES];
    logic [11:0] r_meta  [ROUTE_ENTRIES];

    logic [CW-1:0] r_count, r_rd, r_wr;
    logic [2:0]    r_cmd;
    logic [31:0]   r_addr, r_gwin;
    logic [5:0]    r_len;
    logic          r_gwg;
    logic [3:0]    r_if;
    logic          r_have, r_hit;    // lookup chose; upsert matched
    logic signed [6:0] r_best;
    logic [IW-1:0] r_pick;
    logic [31:0]   r_hgw;
    logic          r_hgwg;
    logic [3:0]    r_hif;

    logic [IW-1:0] w_idx;
    logic [31:0]   w_pa, w_g, w_mask;
    logic [11:0]   w_m, w_new_meta;
    logic [5:0]    w_plen;
    logic          w_def, w_pm, w_same, w_rm;

    assign w_idx  = r_rd[IW-1:0];
    assign w_pa   = r_paddr[w_idx];
    assign w_g    = r_gw[w_idx];
    assign w_m    = r_meta[w_idx];
    assign w_plen = w_m[5:0];
    assign w_def  = w_m[6];
    assign w_mask = (w_plen == 6'd0) ? 32'd0 : (32'hFFFF_FFFF << (6'd32 - w_plen));
    assign w_pm   = ((w_pa ^ r_addr) & w_mask) == 32'd0;
    assign w_same = (r_cmd == lprt_pkg::CMD_SETDEF) ? w_def
                  : (!w_def && w_pa == r_addr && w_plen == r_len);
    assign w_rm   = (w_m[11:8] == r_if) && ((r_cmd == lprt_pkg::CMD_DROP) || w_def);
    assign w_new_meta = {r_if, r_gwg, (r_cmd == lprt_pkg::CMD_SETDEF),
                         (r_cmd == lprt_pkg::CMD_SETDEF) ? 6'd0 : r_len};
    assign o_stat.scan_done = (r_rd >= r_count) || r_hit;
    assign o_count = r_count;

    // command capture and scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd     <= '0;
            r_wr     <= '0;
            r_have   <= 1'b0;
            r_hit    <= 1'b0;
            r_best   <= -7'sd2;
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            if (i_ctrl.load) begin
                r_cmd  <= i_cmd;
                r_addr <= i_address;
                r_len  <= (i_prefix_len > lprt_pkg::MAX_LEN) ? lprt_pkg::MAX_LEN
                                                             : i_prefix_len;
                r_gwin <= i_gateway_given ? i_gateway_addr : 32'd0;
                r_gwg  <= i_gateway_given;
                r_if   <= i_iface_id;
                r_rd   <= '0;
                r_wr   <= '0;
                r_have <= 1'b0;
                r_hit  <= 1'b0;
                r_best <= -7'sd2;
            end
            if (i_ctrl.step) begin
                r_rd <= r_rd + 1'b1;
                case (r_cmd) inside
                    lprt_pkg::CMD_LOOKUP: begin
                        if (w_def) begin
                            if (r_best == -7'sd2) begin
                                r_best <= -7'sd1;
                                r_have <= 1'b1;
                                r_pick <= w_idx;
                            end
                        end else if ($signed({1'b0, w_plen}) > r_best && w_pm) begin
                            r_best <= $signed({1'b0, w_plen});
                            r_have <= 1'b1;
                            r_pick <= w_idx;
                        end
                    end
                    lprt_pkg::CMD_ADD, lprt_pkg::CMD_SETDEF: begin
                        if (w_same) begin
                            r_hit   <= 1'b1;
                            r_pick  <= w_idx;
                        end
                    end
                    lprt_pkg::CMD_UNSET, lprt_pkg::CMD_DROP: begin
                        if (!w_rm) r_wr <= r_wr + 1'b1;
                    end
                    default: ;
                endcase
            end
            if (i_ctrl.finish) begin
                o_strobe <= 1'b1;
                if (r_cmd == lprt_pkg::CMD_UNSET || r_cmd == lprt_pkg::CMD_DROP)
                    r_count <= r_wr;
                else if ((r_cmd == lprt_pkg::CMD_ADD || r_cmd == lprt_pkg::CMD_SETDEF)
                         && !r_hit && r_count < FULL)
                    r_count <= r_count + 1'b1;
            end
        end
    end

    // memory writes: compaction during scan, upsert at finish
    always_ff @(posedge i_clk) begin
        if (i_ctrl.step && (r_cmd == lprt_pkg::CMD_UNSET || r_cmd == lprt_pkg::CMD_DROP)
            && !w_rm) begin
            r_paddr[r_wr[IW-1:0]] <= w_pa;
            r_gw[r_wr[IW-1:0]]    <= w_g;
            r_meta[r_wr[IW-1:0]]  <= w_m;
        end
        if (i_ctrl.finish && (r_cmd == lprt_pkg::CMD_ADD || r_cmd == lprt_pkg::CMD_SETDEF)) begin
            if (r_hit) begin
                r_gw[r_pick]   <= r_gwin;
                r_meta[r_pick] <= w_new_meta;
            end else if (r_count < FULL) begin
                r_paddr[r_count[IW-1:0]] <= (r_cmd == lprt_pkg::CMD_SETDEF) ? 32'd0 : r_addr;
                r_gw[r_count[IW-1:0]]    <= r_gwin;
                r_meta[r_count[IW-1:0]]  <= w_new_meta;
            end
        end
    end

    // registered read of the chosen entry
    always_ff @(posedge i_clk) begin
        r_hgw  <= r_gw[r_pick];
        r_hgwg <= r_meta[r_pick][7];
        r_hif  <= r_meta[r_pick][11:8];
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (i_ctrl.finish) begin
            o_found          <= (r_cmd == lprt_pkg::CMD_LOOKUP) && r_have;
            o_next_hop_given <= (r_cmd == lprt_pkg::CMD_LOOKUP) && r_have && r_hgwg;
            o_next_hop       <= ((r_cmd == lprt_pkg::CMD_LOOKUP) && r_have && r_hgwg)
                                ? r_hgw : 32'd0;
            o_out_iface      <= ((r_cmd == lprt_pkg::CMD_LOOKUP) && r_have) ? r_hif : 4'd0;
            o_status         <= (r_cmd == lprt_pkg::CMD_ADD || r_cmd == lprt_pkg::CMD_SETDEF)
                                && !r_hit && (r_count >= FULL);
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/longest_prefix_route_table.sv -----
// Route table with longest prefix lookup. Each command beat is taken when
// start is high and busy is low; the block then scans the stored entries
// one per cycle. An add or set-default command stops its scan at the
// matching entry. Exactly one result beat follows every command on o_valid
// for one cycle; the receiver cannot stall it.
// depends on lprt_pkg, lprt_ctrl, lprt_datapath and the macros header
`default_nettype none
`include "longest_prefix_route_table_macros.svh"
module longest_prefix_route_table #(
    parameter int ROUTE_ENTRIES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_cmd,
    input  wire logic [31:0] i_address,
    input  wire logic [5:0]  i_prefix_len,
    input  wire logic [31:0] i_gateway_addr,
    input  wire logic        i_gateway_given,
    input  wire logic [3:0]  i_iface_id,
    output logic             o_valid,
    output logic             o_found,
    output logic [31:0]      o_next_hop,
    output logic             o_next_hop_given,
    output logic [3:0]       o_out_iface,
    output logic             o_status
);
    lprt_pkg::t_ctrl w_ctrl;
    lprt_pkg::t_stat w_stat;
    logic [$clog2(ROUTE_ENTRIES+1)-1:0] w_count;

    lprt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl),
        .o_busy  (busy)
    );

    lprt_datapath #(.ROUTE_ENTRIES(ROUTE_ENTRIES)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (w_ctrl),
        .i_cmd            (i_cmd),
        .i_address        (i_address),
        .i_prefix_len     (i_prefix_len),
        .i_gateway_addr   (i_gateway_addr),
        .i_gateway_given  (i_gateway_given),
        .i_iface_id       (i_iface_id),
        .o_stat           (w_stat),
        .o_strobe         (o_valid),
        .o_found          (o_found),
        .o_next_hop       (o_next_hop),
        .o_next_hop_given (o_next_hop_given),
        .o_out_iface      (o_out_iface),
        .o_status         (o_status),
        .o_count          (w_count)
    );

    // checks
    `LPRT_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, w_count <= ($clog2(ROUTE_ENTRIES+1))'(ROUTE_ENTRIES), "route count above depth")
    `LPRT_ASSERT_NEXT(a_finish_beat, i_clk, i_rst_n, w_ctrl.finish, o_valid, "finish gave no result beat")
    `LPRT_ASSERT_IMP(a_beat_idle, i_clk, i_rst_n, o_valid, !busy, "result beat while busy")
endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// self-checking testbench for the longest prefix route table
// depends on lprt_pkg and the longest_prefix_route_table top level
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    localparam logic [2:0] CMD_LOOKUP = lprt_pkg::CMD_LOOKUP;
    localparam logic [2:0] CMD_ADD    = lprt_pkg::CMD_ADD;
    localparam logic [2:0] CMD_SETDEF = lprt_pkg::CMD_SETDEF;
    localparam logic [2:0] CMD_UNSET  = lprt_pkg::CMD_UNSET;
    localparam logic [2:0] CMD_DROP   = lprt_pkg::CMD_DROP;
    localparam logic [5:0] MAX_LEN    = lprt_pkg::MAX_LEN;

    localparam int ENTRIES    = 16;
    localparam int IDLE_LIMIT = 2000;
    localparam int N_RANDOM   = 800;
    localparam logic [2:0] CMD_SPARE = 3'd5;
    localparam logic [2:0] CMD_BAD   = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  i_cmd;
    logic [31:0] i_address;
    logic [5:0]  i_prefix_len;
    logic [31:0] i_gateway_addr;
    logic        i_gateway_given;
    logic [3:0]  i_iface_id;
    logic        o_valid;
    logic        o_found;
    logic [31:0] o_next_hop;
    logic        o_next_hop_given;
    logic [3:0]  o_out_iface;
    logic        o_status;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] addr;
        logic [5:0]  plen;
        logic [31:0] gw;
        logic        gw_given;
        logic [3:0]  iface;
    } t_cmd_beat;

    typedef struct packed {
        logic        found;
        logic [31:0] hop;
        logic        hop_given;
        logic [3:0]  oif;
        logic        status;
    } t_route_result;

    // directed row: beat, whether the result is typed in, and the result
    typedef struct packed {
        t_cmd_beat     beat;
        logic          fixed;
        t_route_result res;
    } t_directed_row;

    // shadow route table
    logic [31:0] shadow_addr [ENTRIES];
    logic [31:0] shadow_gw   [ENTRIES];
    logic [5:0]  shadow_len  [ENTRIES];
    logic        shadow_def  [ENTRIES];
    logic        shadow_gwv  [ENTRIES];
    logic [3:0]  shadow_if   [ENTRIES];
    int          shadow_count;

    t_route_result pending_routes[$];
    int fail_count;
    int beats_sent;
    int beats_seen;
    int lookups_hit;
    int full_seen;
    int idle_cycles;

    longest_prefix_route_table #(.ROUTE_ENTRIES(ENTRIES)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .i_address(i_address), .i_prefix_len(i_prefix_len),
        .i_gateway_addr(i_gateway_addr), .i_gateway_given(i_gateway_given),
        .i_iface_id(i_iface_id), .o_valid(o_valid), .o_found(o_found),
        .o_next_hop(o_next_hop), .o_next_hop_given(o_next_hop_given),
        .o_out_iface(o_out_iface), .o_status(o_status)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // compact the shadow table, dropping hits on iface
    function automatic void shadow_remove(logic [3:0] iface, bit only_def);
        int w;
        w = 0;
        for (int r = 0; r < shadow_count; r++) begin
            if (!(shadow_if[r] == iface && (!only_def || shadow_def[r]))) begin
                shadow_addr[w] = shadow_addr[r];
                shadow_gw[w]   = shadow_gw[r];
                shadow_len[w]  = shadow_len[r];
                shadow_def[w]  = shadow_def[r];
                shadow_gwv[w]  = shadow_gwv[r];
                shadow_if[w]   = shadow_if[r];
                w++;
            end
        end
        shadow_count = w;
    endfunction

    // update in place or append; returns full flag
    function automatic logic shadow_upsert(bit is_def, logic [31:0] addr, logic [5:0] plen,
                                           logic [31:0] gw, logic gwv, logic [3:0] iface);
        int slot;
        slot = -1;
        for (int k = 0; k < shadow_count; k++) begin
            if (slot < 0 && (is_def ? shadow_def[k]
                    : (!shadow_def[k] && shadow_addr[k] == addr && shadow_len[k] == plen)))
                slot = k;
        end
        if (slot < 0) begin
            if (shadow_count >= ENTRIES)
                return 1'b1;
            slot = shadow_count;
            shadow_count++;
            shadow_addr[slot] = is_def ? 32'd0 : addr;
        end
        shadow_gw[slot]   = gw;
        shadow_len[slot]  = is_def ? 6'd0 : plen;
        shadow_def[slot]  = is_def;
        shadow_gwv[slot]  = gwv;
        shadow_if[slot]   = iface;
        return 1'b0;
    endfunction

    // predict the route result of one command beat
    function automatic t_route_result route_predict(t_cmd_beat b);
        t_route_result r;
        logic [5:0]  plen;
        logic [31:0] gw;
        logic [31:0] mask;
        int best;
        int pick;
        r = '0;
        plen = (b.plen > MAX_LEN) ? MAX_LEN : b.plen;
        gw = b.gw_given ? b.gw : 32'd0;
        case (b.cmd)
            CMD_LOOKUP: begin
                best = -2;
                pick = 0;
                for (int k = 0; k < shadow_count; k++) begin
                    if (shadow_def[k]) begin
                        if (best == -2) begin
                            best = -1;
                            pick = k;
                        end
                    end else if (int'(shadow_len[k]) > best) begin
                        mask = (shadow_len[k] == 0) ? 32'd0
                             : (32'hFFFF_FFFF << (32 - shadow_len[k]));
                        if ((shadow_addr[k] & mask) == (b.addr & mask)) begin
                            best = shadow_len[k];
                            pick = k;
                        end
                    end
                end
                if (best != -2) begin
                    r.found     = 1'b1;
                    r.hop_given = shadow_gwv[pick];
                    r.hop       = shadow_gwv[pick] ? shadow_gw[pick] : 32'd0;
                    r.oif       = shadow_if[pick];
                end
            end
            CMD_ADD:    r.status = shadow_upsert(0, b.addr, plen, gw, b.gw_given, b.iface);
            CMD_SETDEF: r.status = shadow_upsert(1, 32'd0, 6'd0, gw, b.gw_given, b.iface);
            CMD_UNSET:  shadow_remove(b.iface, 1);
            CMD_DROP:   shadow_remove(b.iface, 0);
            default: ;
        endcase
        return r;
    endfunction

    // queue one expected result beat at the back
    function automatic void expect_route(t_route_result r);
        pending_routes.insert(pending_routes.size(), r);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] %s: got %h expected %h", $realtime, what, got, want);
        fail_count++;
    endtask

    // drive one beat at a falling edge and hold it until the block takes it
    task automatic send_beat(t_cmd_beat b, int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_cmd           <= b.cmd;
        i_address       <= b.addr;
        i_prefix_len    <= b.plen;
        i_gateway_addr  <= b.gw;
        i_gateway_given <= b.gw_given;
        i_iface_id      <= b.iface;
        start           <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic send_checked(t_cmd_beat b, int gap);
        expect_route(route_predict(b));
        send_beat(b, gap);
    endtask

    function automatic t_cmd_beat rand_beat(int addr_pool);
        t_cmd_beat b;
        int pick;
        b.addr     = (addr_pool > 0) ? {8'd10, 8'($urandom_range(0, addr_pool)), 16'($urandom)}
                                     : $urandom;
        b.plen     = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 32));
        b.gw       = $urandom;
        b.gw_given = 1'($urandom_range(0, 1));
        b.iface    = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 50)      b.cmd = CMD_LOOKUP;
        else if (pick < 78) b.cmd = CMD_ADD;
        else if (pick < 86) b.cmd = CMD_SETDEF;
        else if (pick < 92) b.cmd = CMD_UNSET;
        else if (pick < 97) b.cmd = CMD_DROP;
        else                b.cmd = 3'($urandom_range(5, 7));
        return b;
    endfunction

    // result checker at the rising edge
    always @(posedge i_clk) begin
        t_route_result want;
        if (i_rst_n && o_valid) begin
            beats_seen++;
            if (pending_routes.size() == 0) begin
                $display("[%0t] result beat with nothing expected", $realtime);
                fail_count++;
            end else begin
                want = pending_routes.pop_front();
                if (o_found !== want.found) report_mismatch("found", o_found, want.found);
                if (o_next_hop !== want.hop) report_mismatch("next_hop", o_next_hop, want.hop);
                if (o_next_hop_given !== want.hop_given)
                    report_mismatch("next_hop_given", o_next_hop_given, want.hop_given);
                if (o_out_iface !== want.oif)
                    report_mismatch("out_iface", o_out_iface, want.oif);
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
                if (want.found) lookups_hit++;
                if (want.status) full_seen++;
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_directed_row directed[$];
        t_cmd_beat b;
        int drain;
        fail_count = 0; beats_sent = 0; beats_seen = 0;
        lookups_hit = 0; full_seen = 0; idle_cycles = 0;
        for (int k = 0; k < ENTRIES; k++) begin
            shadow_addr[k] = '0; shadow_gw[k] = '0; shadow_len[k] = '0;
            shadow_def[k] = 0; shadow_gwv[k] = 0; shadow_if[k] = '0;
        end
        shadow_count = 0;
        i_rst_n = 1'b0; start = 1'b0; i_cmd = CMD_LOOKUP; i_address = '0;
        i_prefix_len = '0; i_gateway_addr = '0; i_gateway_given = 1'b0; i_iface_id = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows; typed results for early rows and unknown commands
        directed = '{
            '{'{CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'd0, 1'b0, 4'd0}, 1'b1, '0},
            '{'{CMD_UNSET, 32'd0, 6'd0, 32'd0, 1'b0, 4'd15}, 1'b1, '0},
            '{'{CMD_SETDEF, 32'hDEAD_BEEF, 6'd9, 32'hC0A8_0001, 1'b1, 4'd3}, 1'b1, '0},
            '{'{CMD_LOOKUP, 32'h0101_0101, 6'd0, 32'd0, 1'b0, 4'd0}, 1'b1,
              '{1'b1, 32'hC0A8_0001, 1'b1, 4'd3, 1'b0}},
            '{'{CMD_ADD, 32'h0A00_0000, 6'd8, 32'hFFFF_FFFF, 1'b0, 4'd1}, 1'b1, '0},
            '{'{CMD_ADD, 32'h0A01_0000, 6'd16, 32'hFFFF_FFFF, 1'b1, 4'd2}, 1'b0, '0},
            '{'{CMD_ADD, 32'h0A01_0203, 6'd63, 32'h0000_0001, 1'b1, 4'd15}, 1'b0, '0},
            '{'{CMD_ADD, 32'h0000_0000, 6'd0, 32'h0A0A_0A0A, 1'b1, 4'd4}, 1'b0, '0},
            '{'{CMD_LOOKUP, 32'h0A01_0203, 6'd0, 32'd0, 1'b0, 4'd0}, 1'b0, '0},
            '{'{CMD_LOOKUP, 32'h0A01_FFFF, 6'd0, 32'd0, 1'b0, 4'd0}, 1'b0, '0},
            '{'{CMD_LOOKUP, 32'h0AFF_0000, 6'd0, 32'd0, 1'b0, 4'd0}, 1'b0, '0},
            '{'{CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0, 32'd0, 1'b0, 4'd0}, 1'b0, '0},
            '{'{CMD_ADD, 32'h0A01_0000, 6'd16, 32'h1234_5678, 1'b1, 4'd7}, 1'b0, '0},
            '{'{CMD_ADD, 32'h0A01_0001, 6'd16, 32'h1111_1111, 1'b1, 4'd8}, 1'b0, '0},
            '{'{CMD_LOOKUP, 32'h0A01_0009, 6'd0, 32'd0, 1'b0, 4'd0}, 1'b0, '0},
            '{'{CMD_SETDEF, 32'd0, 6'd0, 32'h0, 1'b0, 4'd9}, 1'b0, '0},
            '{'{CMD_SPARE, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 1'b1, 4'd15}, 1'b1, '0},
            '{'{CMD_BAD, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 1'b1, 4'd15}, 1'b1, '0},
            '{'{CMD_UNSET, 32'd0, 6'd0, 32'd0, 1'b0, 4'd9}, 1'b0, '0},
            '{'{CMD_LOOKUP, 32'h0B00_0000, 6'd0, 32'd0, 1'b0, 4'd0}, 1'b0, '0},
            '{'{CMD_DROP, 32'd0, 6'd0, 32'd0, 1'b0, 4'd4}, 1'b0, '0},
            '{'{CMD_LOOKUP, 32'h0B00_0000, 6'd0, 32'd0, 1'b0, 4'd0}, 1'b0, '0}
        };
        foreach (directed[n]) begin
            if (directed[n].fixed) begin
                void'(route_predict(directed[n].beat));
                expect_route(directed[n].res);
                send_beat(directed[n].beat, 0);
            end else begin
                send_checked(directed[n].beat, $urandom_range(0, 3));
            end
        end

        // fill the table to full, then adds and a set-default past full
        for (int k = 0; k < ENTRIES + 2; k++) begin
            b = '{CMD_ADD, {8'd20, 8'(k), 16'd0}, 6'd24, $urandom, 1'b1, 4'(k)};
            send_checked(b, 0);
        end
        b = '{CMD_SETDEF, 32'd0, 6'd0, 32'hFFFF_FFFF, 1'b1, 4'd15};
        send_checked(b, 0);
        for (int k = 0; k < 16; k++) begin
            b = '{CMD_DROP, 32'd0, 6'd0, 32'd0, 1'b0, 4'(k)};
            send_checked(b, 0);
        end

        // random beats, mostly over a small address pool so matches are common
        for (int n = 0; n < N_RANDOM; n++) begin
            b = rand_beat(($urandom_range(0, 9) == 0) ? 0 : 3);
            if ($urandom_range(0, 4) == 0)
                send_checked(b, 0);
            else
                send_checked(b, $urandom_range(0, 16));
        end
        @(negedge i_clk);
        start <= 1'b0;

        // drain
        drain = 0;
        while (pending_routes.size() != 0 && drain < IDLE_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (ENTRIES + 8) @(posedge i_clk);
        $display("sent %0d command beats, %0d result beats, %0d lookups hit, %0d table full",
                 beats_sent, beats_seen, lookups_hit, full_seen);
        if (pending_routes.size() != 0) begin
            $display("%0d results never arrived", pending_routes.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire
